// ----- rtl/core/capsule_vertex_generator_defines.svh -----
// Assertion macros used by the capsule vertex generator checker.
`ifndef CAPSULE_VERTEX_GENERATOR_DEFINES_SVH
`define CAPSULE_VERTEX_GENERATOR_DEFINES_SVH

// Clocked assertion, switched off while reset is high.
`define CVG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that must also hold through reset.
`define CVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/cvg_pkg.sv -----
// Shared constants, stage types and angle table functions of the capsule vertex generator.
package cvg_pkg;

   // mesh resolution; stacks kept a power of two so the body y divide is a shift
   localparam int SLICES      = 32;
   localparam int STACKS_LOG2 = 4;
   localparam int STACKS      = 1 << STACKS_LOG2;
   localparam int HALF_STACKS = STACKS / 2;

   // field widths
   localparam int SEC_W   = 2;
   localparam int RING_W  = 5;
   localparam int SLICE_W = 6;
   localparam int CFG_W   = 16;
   localparam int POS_W   = 18;
   localparam int TEX_W   = 17;

   // table index widths
   localparam int SLICE_IW = $clog2(SLICES + 1);
   localparam int BODY_IW  = $clog2(STACKS + 1);
   localparam int CAP_IW   = $clog2(HALF_STACKS + 1);
   localparam int RO_W     = BODY_IW + 1;

   // datapath widths
   localparam int TRIG_W    = 18;
   localparam int TRIG_FRAC = 16;
   localparam int PROD_W    = 34;
   localparam int WIDE_W    = 50;

   // stream packing
   localparam int REQ_FIELDS = RING_W + SLICE_W;
   localparam int REQ_DW     = ((REQ_FIELDS + 7) / 8) * 8;
   localparam int RSP_FIELDS = 3 * POS_W + 2 * TEX_W;
   localparam int RSP_DW     = ((RSP_FIELDS + 7) / 8) * 8;

   // configuration
   localparam int CSR_IW = 1;
   localparam logic [CFG_W-1:0] RADIUS_RESET = CFG_W'(256);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(512);

   typedef enum logic [CSR_IW-1:0] {
      CSR_CAP_RADIUS  = 1'b0,
      CSR_BODY_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [SEC_W-1:0] {
      SEC_BODY   = 2'd0,
      SEC_TOP    = 2'd1,
      SEC_BOTTOM = 2'd2
   } section_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_type;

   // after table lookup
   typedef struct packed {
      logic                   ok;
      logic                   is_cap;
      logic                   is_bottom;
      trig_type               theta;
      trig_type               phi;
      logic signed [RO_W-1:0] ring_off;
      logic [TEX_W-1:0]       tex_u;
      logic [TEX_W-1:0]       tex_v;
   } s1_type;

   // after first products
   typedef struct packed {
      logic                     ok;
      logic                     is_cap;
      logic                     is_bottom;
      logic signed [PROD_W-1:0] p_x;
      logic signed [PROD_W-1:0] p_z;
      logic signed [PROD_W-1:0] p_y;
      logic [TEX_W-1:0]         tex_u;
      logic [TEX_W-1:0]         tex_v;
   } s2_type;

   // after second products, before rounding
   typedef struct packed {
      logic                     ok;
      logic                     is_cap;
      logic                     is_bottom;
      logic signed [WIDE_W-1:0] m_x;
      logic signed [WIDE_W-1:0] m_z;
      logic signed [WIDE_W-1:0] y_sum;
      logic signed [PROD_W-1:0] p_x;
      logic signed [PROD_W-1:0] p_z;
      logic [TEX_W-1:0]         tex_u;
      logic [TEX_W-1:0]         tex_v;
   } s3_type;

   localparam logic [63:0] ONE_Q32      = 64'd4294967296;
   localparam logic [63:0] HALF_PI_Q32  = 64'd6746518852;
   localparam logic [63:0] QUARTER_TURN = 64'd1073741824;
   localparam logic [63:0] EIGHTH_TURN  = 64'd536870912;

   // Taylor series in Q0.32, only ever evaluated on constants
   function automatic logic [63:0] poly_sin(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (r * HALF_PI_Q32) >> 30;
      x2 = (x * x) >> 32;
      t  = ONE_Q32 - x2 / 72;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 42;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 20;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 6;
      return (x * t) >> 32;
   endfunction

   function automatic logic [63:0] poly_cos(input logic [63:0] r);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (r * HALF_PI_Q32) >> 30;
      x2 = (x * x) >> 32;
      t  = ONE_Q32 - x2 / 90;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 56;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 30;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 12;
      t  = ONE_Q32 - ((x2 * t) >> 32) / 2;
      return t;
   endfunction

   function automatic logic signed [TRIG_W-1:0] to_q16(input logic [63:0] v);
      logic [63:0] q;
      q = (v + 64'd32768) >> 16;
      return $signed(q[TRIG_W-1:0]);
   endfunction

   // sine and cosine of a phase in 2^-32 turn, Q2.16
   function automatic trig_type sin_cos(input logic [31:0] phase);
      logic [63:0]              r;
      logic signed [TRIG_W-1:0] s0;
      logic signed [TRIG_W-1:0] c0;
      trig_type                 res;
      r = {34'd0, phase[29:0]};
      if (r <= EIGHTH_TURN) begin
         s0 = to_q16(poly_sin(r));
         c0 = to_q16(poly_cos(r));
      end else begin
         s0 = to_q16(poly_cos(QUARTER_TURN - r));
         c0 = to_q16(poly_sin(QUARTER_TURN - r));
      end
      unique case (phase[31:30])
         2'd0: begin
            res.s = s0;
            res.c = c0;
         end
         2'd1: begin
            res.s = c0;
            res.c = -s0;
         end
         2'd2: begin
            res.s = -s0;
            res.c = -c0;
         end
         default: begin
            res.s = -c0;
            res.c = s0;
         end
      endcase
      return res;
   endfunction

   function automatic trig_type theta_entry(input int idx);
      logic [63:0] p;
      p = (64'(idx) << 32) / 64'(SLICES);
      return sin_cos(p[31:0]);
   endfunction

   function automatic trig_type phi_entry(input int idx);
      logic [63:0] p;
      p = (64'(idx) << 30) / 64'(HALF_STACKS);
      return sin_cos(p[31:0]);
   endfunction

   function automatic logic [TEX_W-1:0] body_u_entry(input int idx);
      logic [63:0] v;
      v = (64'(idx) * 64'd131072 + 64'(SLICES)) / 64'(2 * SLICES);
      return v[TEX_W-1:0];
   endfunction

   function automatic logic [TEX_W-1:0] body_v_entry(input int idx);
      logic [63:0] v;
      v = (64'(STACKS - idx) * 64'd131072 + 64'(STACKS)) / 64'(2 * STACKS);
      return v[TEX_W-1:0];
   endfunction

endpackage

// ----- rtl/core/cvg_lookup.sv -----
// Request decode, range check and angle table lookup stage.
module cvg_lookup import cvg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [SEC_W-1:0]   section_in,
   input  logic [RING_W-1:0]  ring_in,
   input  logic [SLICE_W-1:0] slice_in,
   output logic               out_valid,
   input  logic               out_ready,
   output s1_type             out_data
);

   trig_type         theta_tab [SLICES+1];
   trig_type         phi_tab   [HALF_STACKS+1];
   logic [TEX_W-1:0] u_tab     [SLICES+1];
   logic [TEX_W-1:0] v_tab     [STACKS+1];

   for (genvar i = 0; i <= SLICES; i++) begin : g_slice_tab
      assign theta_tab[i] = theta_entry(i);
      assign u_tab[i]     = body_u_entry(i);
   end

   for (genvar i = 0; i <= HALF_STACKS; i++) begin : g_phi_tab
      assign phi_tab[i] = phi_entry(i);
   end

   for (genvar i = 0; i <= STACKS; i++) begin : g_v_tab
      assign v_tab[i] = body_v_entry(i);
   end

   logic                ok;
   logic                is_cap;
   logic                is_bottom;
   logic [SLICE_IW-1:0] slice_idx;
   logic [BODY_IW-1:0]  body_idx;
   logic [CAP_IW-1:0]   cap_idx;
   s1_type              s1_in;
   s1_type              s1_ff;
   logic                v1_ff;

   always_comb begin
      ok        = 1'b0;
      is_cap    = 1'b0;
      is_bottom = 1'b0;
      unique case (section_in)
         SEC_BODY: ok = (ring_in <= RING_W'(STACKS));
         SEC_TOP: begin
            ok     = (ring_in <= RING_W'(HALF_STACKS));
            is_cap = 1'b1;
         end
         SEC_BOTTOM: begin
            ok        = (ring_in <= RING_W'(HALF_STACKS));
            is_cap    = 1'b1;
            is_bottom = 1'b1;
         end
         default: ok = 1'b0;
      endcase
      if (slice_in > SLICE_W'(SLICES)) ok = 1'b0;

      // gated indexes keep every read inside its table
      slice_idx = ok ? slice_in[SLICE_IW-1:0] : '0;
      body_idx  = (ok && !is_cap) ? ring_in[BODY_IW-1:0] : '0;
      cap_idx   = (ok && is_cap) ? ring_in[CAP_IW-1:0] : '0;

      s1_in.ok        = ok;
      s1_in.is_cap    = is_cap;
      s1_in.is_bottom = is_bottom;
      s1_in.theta     = theta_tab[slice_idx];
      s1_in.phi       = phi_tab[cap_idx];
      s1_in.ring_off  = RO_W'({body_idx, 1'b0}) - RO_W'(STACKS);
      s1_in.tex_u     = u_tab[slice_idx];
      s1_in.tex_v     = v_tab[body_idx];
   end

   assign in_ready = !v1_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (in_ready) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ff <= s1_in;
      end
   end

   assign out_valid = v1_ff;
   assign out_data  = s1_ff;

endmodule

// ----- rtl/core/cvg_mult.sv -----
// Two multiplier stages: trig products, then radius scaling and cap height sum.
module cvg_mult import cvg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] radius,
   input  logic [CFG_W-1:0] height,
   input  logic             in_valid,
   output logic             in_ready,
   input  s1_type           in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output s3_type           out_data
);

   logic signed [TRIG_W-1:0] r_t;
   logic signed [TRIG_W-1:0] h_t;
   logic signed [TRIG_W-1:0] a_t;
   logic signed [WIDE_W-1:0] cap_h;
   s2_type                   s2_in;
   s2_type                   s2_ff;
   logic                     v2_ff;
   logic                     s2_ready;
   s3_type                   s3_in;
   s3_type                   s3_ff;
   logic                     v3_ff;

   assign r_t = $signed({{(TRIG_W-CFG_W){1'b0}}, radius});
   assign h_t = $signed({{(TRIG_W-CFG_W){1'b0}}, height});
   // H/2 in the Q8.24 scale of R*sin(phi)
   assign cap_h = $signed({{(WIDE_W-CFG_W-15){1'b0}}, height, 15'd0});

   // stage 2: cos(phi) or R against the theta pair, and the y term
   always_comb begin
      a_t             = in_data.is_cap ? in_data.phi.c : r_t;
      s2_in.ok        = in_data.ok;
      s2_in.is_cap    = in_data.is_cap;
      s2_in.is_bottom = in_data.is_bottom;
      s2_in.p_x       = PROD_W'(a_t) * PROD_W'(in_data.theta.c);
      s2_in.p_z       = PROD_W'(a_t) * PROD_W'(in_data.theta.s);
      s2_in.p_y       = in_data.is_cap ? PROD_W'(r_t) * PROD_W'(in_data.phi.s)
                                       : PROD_W'(h_t) * PROD_W'(in_data.ring_off);
      s2_in.tex_u     = in_data.tex_u;
      s2_in.tex_v     = in_data.tex_v;
   end

   assign s2_ready = !v3_ff || out_ready;
   assign in_ready = !v2_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (in_ready) begin
         v2_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: caps take a second factor of R; the body passes through
   always_comb begin
      s3_in.ok        = s2_ff.ok;
      s3_in.is_cap    = s2_ff.is_cap;
      s3_in.is_bottom = s2_ff.is_bottom;
      s3_in.m_x       = s2_ff.is_cap ? WIDE_W'(r_t) * WIDE_W'(s2_ff.p_x) : WIDE_W'(s2_ff.p_x);
      s3_in.m_z       = s2_ff.is_cap ? WIDE_W'(r_t) * WIDE_W'(s2_ff.p_z) : WIDE_W'(s2_ff.p_z);
      s3_in.y_sum     = s2_ff.is_cap ? cap_h + WIDE_W'(s2_ff.p_y) : WIDE_W'(s2_ff.p_y);
      s3_in.p_x       = s2_ff.p_x;
      s3_in.p_z       = s2_ff.p_z;
      s3_in.tex_u     = s2_ff.tex_u;
      s3_in.tex_v     = s2_ff.tex_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (s2_ready) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

// ----- rtl/core/cvg_round.sv -----
// Rounding, saturation, result packing and the output register.
module cvg_round import cvg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  s3_type            in_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic              rsp_tuser
);

   localparam logic signed [WIDE_W-1:0] Y_MAX    = WIDE_W'((1 << (POS_W - 1)) - 1);
   localparam logic signed [WIDE_W-1:0] Y_MIN    = -Y_MAX - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] TEX_HALF = WIDE_W'(1 << (TEX_W - 2));

   // divide by 2^sh, nearest, ties away from zero
   function automatic logic signed [WIDE_W-1:0] rnd_shift(input logic signed [WIDE_W-1:0] p,
                                                         input int sh);
      logic [WIDE_W-1:0] mag;
      mag = p[WIDE_W-1] ? (~p + 1'b1) : p;
      mag = (mag + (WIDE_W'(1) << (sh - 1))) >> sh;
      return p[WIDE_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

   logic signed [WIDE_W-1:0] x_r;
   logic signed [WIDE_W-1:0] z_r;
   logic signed [WIDE_W-1:0] y_top;
   logic signed [WIDE_W-1:0] y_sat;
   logic signed [WIDE_W-1:0] y_r;
   logic signed [WIDE_W-1:0] u_cap;
   logic signed [WIDE_W-1:0] v_cap;
   logic [TEX_W-1:0]         tex_u;
   logic [TEX_W-1:0]         tex_v;
   logic [RSP_DW-1:0]        data_in;
   logic [RSP_DW-1:0]        data_ff;
   logic                     ok_ff;
   logic                     vo_ff;

   always_comb begin
      x_r   = in_data.is_cap ? rnd_shift(in_data.m_x, 2 * TRIG_FRAC)
                             : rnd_shift(in_data.m_x, TRIG_FRAC);
      z_r   = in_data.is_cap ? rnd_shift(in_data.m_z, 2 * TRIG_FRAC)
                             : rnd_shift(in_data.m_z, TRIG_FRAC);
      y_top = rnd_shift(in_data.y_sum, TRIG_FRAC);
      if (y_top > Y_MAX) begin
         y_sat = Y_MAX;
      end else if (y_top < Y_MIN) begin
         y_sat = Y_MIN;
      end else begin
         y_sat = y_top;
      end
      // the top value is never below -Y_MAX, so its negation needs no clip
      if (!in_data.is_cap) begin
         y_r = rnd_shift(in_data.y_sum, STACKS_LOG2 + 1);
      end else if (in_data.is_bottom) begin
         y_r = -y_sat;
      end else begin
         y_r = y_sat;
      end
      u_cap = TEX_HALF + rnd_shift(WIDE_W'(in_data.p_x), TRIG_FRAC + 1);
      v_cap = TEX_HALF + rnd_shift(WIDE_W'(in_data.p_z), TRIG_FRAC + 1);
      tex_u = in_data.is_cap ? u_cap[TEX_W-1:0] : in_data.tex_u;
      tex_v = in_data.is_cap ? v_cap[TEX_W-1:0] : in_data.tex_v;
      if (in_data.ok) begin
         data_in = RSP_DW'({tex_v, tex_u, z_r[POS_W-1:0], y_r[POS_W-1:0], x_r[POS_W-1:0]});
      end else begin
         data_in = '0;
      end
   end

   assign in_ready = !vo_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (in_ready) begin
         vo_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
         ok_ff   <= in_data.ok;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = ok_ff;

endmodule

// ----- rtl/core/capsule_vertex_generator.sv -----
// Capsule vertex generator: one mesh vertex position and texture coordinate per request.
// Pipeline from request accepted to result shown: lookup, two multiply stages, round.
// Throughput: one request per cycle while results are taken; each stage holds while its successor is full and stalled.
// Synchronous active-high reset empties the pipeline and sets radius 1.0 and height 2.0.
// No clearing pass: angle and texture tables are constant logic.
module capsule_vertex_generator import cvg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,  // ring [4:0], slice [10:5], zero pad
   input  logic [SEC_W-1:0]  req_tuser,  // section [1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v from bit 0
   output logic [0:0]        rsp_tuser,  // valid_res [0]
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   logic [CFG_W-1:0] radius_ff;
   logic [CFG_W-1:0] radius_in;
   logic [CFG_W-1:0] height_ff;
   logic [CFG_W-1:0] height_in;

   always_comb begin
      radius_in = radius_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAP_RADIUS:  radius_in = csr_wdata;
            CSR_BODY_HEIGHT: height_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         radius_ff <= radius_in;
         height_ff <= height_in;
      end
   end

   s1_type s1_data;
   logic   s1_valid;
   logic   s1_ready;
   s3_type s3_data;
   logic   s3_valid;
   logic   s3_ready;

   cvg_lookup u_lookup (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .section_in (req_tuser),
      .ring_in    (req_tdata[RING_W-1:0]),
      .slice_in   (req_tdata[REQ_FIELDS-1:RING_W]),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .out_data   (s1_data)
   );

   cvg_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .height    (height_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   cvg_round u_round (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s3_valid),
      .in_ready   (s3_ready),
      .in_data    (s3_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser[0])
   );

endmodule

// ----- rtl/core/cvg_checker.sv -----
// Port-level checks of the capsule vertex generator, bound to the top level.
`include "capsule_vertex_generator_defines.svh"

module cvg_checker import cvg_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic [0:0]        rsp_tuser
);

   logic signed [POS_W-1:0] pos_x;
   logic [TEX_W-1:0]        tex_u;

   assign pos_x = rsp_tdata[POS_W-1:0];
   assign tex_u = rsp_tdata[3*POS_W+TEX_W-1:3*POS_W];

   `CVG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `CVG_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   `CVG_ASSERT(a_bad_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0, "rejected request gave nonzero data")

   `CVG_ASSERT(a_ranges, clock, reset, rsp_tvalid |-> tex_u <= TEX_W'(65536) && pos_x <= POS_W'(65536) && pos_x >= -POS_W'(65536), "position or texture out of range")

endmodule

bind capsule_vertex_generator cvg_checker u_checker (.*);

// ----- dv/capsule_vertex_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking stream testbench for the capsule vertex generator, with its own vertex predictor.
module capsule_vertex_generator_tb;
   import cvg_pkg::*;

   localparam logic [63:0] Q32_ONE       = 64'h1_0000_0000;
   localparam logic [63:0] Q32_HALF_PI   = 64'd6746518852;
   localparam logic [63:0] PHASE_QUARTER = 64'h4000_0000;
   localparam logic [63:0] PHASE_EIGHTH  = 64'h2000_0000;
   localparam logic [SEC_W-1:0] SEC_UNUSED = 2'd3;

   typedef struct packed {
      logic [SEC_W-1:0]   sec;
      logic [RING_W-1:0]  ring;
      logic [SLICE_W-1:0] slice;
   } vertex_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic                    valid_res;
   } vertex_type;

   typedef struct packed {
      logic [SEC_W-1:0]   sec;
      logic [RING_W-1:0]  ring;
      logic [SLICE_W-1:0] slice;
      logic               typed;
      vertex_type         want;
   } table_row_type;

   // rows with typed values assume the reset radius 1.0 and height 2.0
   localparam int DIR_ROWS_N = 22;
   localparam table_row_type DIR_ROWS [DIR_ROWS_N] = '{
      '{SEC_BODY,   5'd0,  6'd0,  1'b1, '{18'sd256, -18'sd256, 18'sd0, 17'd0, 17'd65536, 1'b1}},
      '{SEC_BODY,   5'd16, 6'd32, 1'b1, '{18'sd256, 18'sd256, 18'sd0, 17'd65536, 17'd0, 1'b1}},
      '{SEC_TOP,    5'd0,  6'd0,  1'b1,
        '{18'sd256, 18'sd256, 18'sd0, 17'd65536, 17'd32768, 1'b1}},
      '{SEC_TOP,    5'd8,  6'd0,  1'b1, '{18'sd0, 18'sd512, 18'sd0, 17'd32768, 17'd32768, 1'b1}},
      '{SEC_BOTTOM, 5'd8,  6'd0,  1'b1,
        '{18'sd0, -18'sd512, 18'sd0, 17'd32768, 17'd32768, 1'b1}},
      '{SEC_BODY,   5'd8,  6'd8,  1'b0, '0},
      '{SEC_BODY,   5'd5,  6'd13, 1'b0, '0},
      '{SEC_TOP,    5'd3,  6'd5,  1'b0, '0},
      '{SEC_TOP,    5'd8,  6'd32, 1'b0, '0},
      '{SEC_BOTTOM, 5'd0,  6'd16, 1'b0, '0},
      '{SEC_BOTTOM, 5'd4,  6'd24, 1'b0, '0},
      '{SEC_TOP,    5'd7,  6'd31, 1'b0, '0},
      '{SEC_BODY,   5'd16, 6'd31, 1'b0, '0},
      '{SEC_BODY,   5'd16, 6'd0,  1'b0, '0},
      '{SEC_BOTTOM, 5'd8,  6'd32, 1'b0, '0},
      // out of range: all fields zero
      '{SEC_BODY,   5'd17, 6'd0,  1'b1, '0},
      '{SEC_TOP,    5'd9,  6'd0,  1'b1, '0},
      '{SEC_BOTTOM, 5'd31, 6'd0,  1'b1, '0},
      '{SEC_BODY,   5'd0,  6'd33, 1'b1, '0},
      '{SEC_TOP,    5'd0,  6'd63, 1'b1, '0},
      '{SEC_UNUSED, 5'd0,  6'd0,  1'b1, '0},
      '{SEC_UNUSED, 5'd31, 6'd63, 1'b1, '0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;   // ring, slice, zero pad
   logic [SEC_W-1:0]  req_tuser;   // section
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v
   logic [0:0]        rsp_tuser;   // valid_res
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   vertex_type     vertex_q[$];
   logic [CFG_W-1:0] mdl_radius;
   logic [CFG_W-1:0] mdl_height;
   bit             idle_on;
   int             fail_count;

   capsule_vertex_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Horner form of the Taylor series in Q0.32; angle r in 2^-32 turn, r <= 1/8 turn
   function automatic logic [63:0] series_q32(input logic [63:0] r, input bit cosine);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] d;
      x  = (r * Q32_HALF_PI) >> 30;
      x2 = (x * x) >> 32;
      t  = Q32_ONE;
      for (int k = cosine ? 5 : 4; k >= 1; k--) begin
         d = cosine ? 64'(2 * k * (2 * k - 1)) : 64'((2 * k + 1) * 2 * k);
         t = Q32_ONE - ((x2 * t) >> 32) / d;
      end
      return cosine ? t : (x * t) >> 32;
   endfunction

   function automatic longint q16_of(input logic [63:0] v);
      return longint'((v + 64'd32768) >> 16);
   endfunction

   // sine and cosine of a full 32-bit phase, Q2.16
   function automatic void phase_sin_cos(input logic [31:0] phase, output longint s,
                                         output longint c);
      logic [63:0] r;
      longint      a;
      longint      b;
      r = {34'd0, phase[29:0]};
      if (r <= PHASE_EIGHTH) begin
         a = q16_of(series_q32(r, 1'b0));
         b = q16_of(series_q32(r, 1'b1));
      end else begin
         a = q16_of(series_q32(PHASE_QUARTER - r, 1'b1));
         b = q16_of(series_q32(PHASE_QUARTER - r, 1'b0));
      end
      case (phase[31:30])
         2'd0: begin
            s = a;
            c = b;
         end
         2'd1: begin
            s = b;
            c = -a;
         end
         2'd2: begin
            s = -a;
            c = -b;
         end
         default: begin
            s = -b;
            c = a;
         end
      endcase
   endfunction

   // nearest, ties away from zero
   function automatic longint round_away(input longint p, input int sh);
      longint m;
      m = (p < 0) ? -p : p;
      m = (m + (longint'(1) << (sh - 1))) >> sh;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint clip_y(input longint y);
      if (y > 131071) return 131071;
      if (y < -131072) return -131072;
      return y;
   endfunction

   function automatic vertex_type predict_vertex(input vertex_req_type rq);
      vertex_type  v;
      bit          in_range;
      logic [63:0] ph;
      longint      st, ct, sp, cp;
      longint      rad, hgt, rng, slc;
      longint      x, y, z, u, w, num, mag;
      v = '0;
      if (rq.sec == SEC_BODY) in_range = rq.ring <= STACKS;
      else if (rq.sec == SEC_TOP || rq.sec == SEC_BOTTOM) in_range = rq.ring <= HALF_STACKS;
      else in_range = 1'b0;
      if (rq.slice > SLICES) in_range = 1'b0;
      if (!in_range) return v;
      rad = longint'(mdl_radius);
      hgt = longint'(mdl_height);
      rng = longint'(rq.ring);
      slc = longint'(rq.slice);
      ph  = (64'(rq.slice) << 32) / 64'(SLICES);
      phase_sin_cos(ph[31:0], st, ct);
      if (rq.sec == SEC_BODY) begin
         num = hgt * (2 * rng - STACKS);
         mag = (((num < 0) ? -num : num) + STACKS) / (2 * STACKS);
         y   = (num < 0) ? -mag : mag;
         x   = round_away(rad * ct, 16);
         z   = round_away(rad * st, 16);
         u   = (slc * 131072 + SLICES) / (2 * SLICES);
         w   = ((STACKS - rng) * 131072 + STACKS) / (2 * STACKS);
      end else begin
         ph = (64'(rq.ring) << 30) / 64'(HALF_STACKS);
         phase_sin_cos(ph[31:0], sp, cp);
         x = round_away(rad * cp * ct, 32);
         z = round_away(rad * cp * st, 32);
         y = clip_y(round_away(hgt * 32768 + rad * sp, 16));
         if (rq.sec == SEC_BOTTOM) y = clip_y(-y);
         u = 32768 + round_away(cp * ct, 17);
         w = 32768 + round_away(cp * st, 17);
      end
      v.pos_x     = POS_W'(x);
      v.pos_y     = POS_W'(y);
      v.pos_z     = POS_W'(z);
      v.tex_u     = TEX_W'(u);
      v.tex_v     = TEX_W'(w);
      v.valid_res = 1'b1;
      return v;
   endfunction

   // mostly well-formed requests; the rest uses the full width of every field
   function automatic vertex_req_type random_request();
      vertex_req_type rq;
      if ($urandom_range(0, 99) < 85) begin
         rq.sec   = SEC_W'($urandom_range(SEC_BODY, SEC_BOTTOM));
         rq.ring  = RING_W'($urandom_range(0, (rq.sec == SEC_BODY) ? STACKS : HALF_STACKS));
         rq.slice = SLICE_W'($urandom_range(0, SLICES));
      end else begin
         rq.sec   = SEC_W'($urandom);
         rq.ring  = RING_W'($urandom);
         rq.slice = SLICE_W'($urandom);
      end
      return rq;
   endfunction

   function automatic void check_field(input string what, input longint want,
                                       input longint got);
      if (want != got) begin
         if (fail_count < 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_request(input vertex_req_type rq, input bit typed,
                               input vertex_type typed_want);
      vertex_type exp_v;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.sec;
      req_tdata  <= REQ_DW'({rq.slice, rq.ring});
      do @(posedge clock); while (!req_tready);
      exp_v    = typed ? typed_want : predict_vertex(rq);
      vertex_q = {vertex_q, exp_v};
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_CAP_RADIUS) mdl_radius = value;
      else mdl_height = value;
   endtask

   // stop sending and let every outstanding request come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      vertex_type got;
      vertex_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos_x     = rsp_tdata[POS_W-1:0];
         got.pos_y     = rsp_tdata[2*POS_W-1:POS_W];
         got.pos_z     = rsp_tdata[3*POS_W-1:2*POS_W];
         got.tex_u     = rsp_tdata[3*POS_W+TEX_W-1:3*POS_W];
         got.tex_v     = rsp_tdata[3*POS_W+2*TEX_W-1:3*POS_W+TEX_W];
         got.valid_res = rsp_tuser[0];
         if (vertex_q.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result: pos %0d %0d %0d, tex %0d %0d, valid %0d",
                        got.pos_x, got.pos_y, got.pos_z, got.tex_u, got.tex_v,
                        got.valid_res);
            fail_count++;
         end else begin
            want = vertex_q.pop_front();
            check_field("pos_x", want.pos_x, got.pos_x);
            check_field("pos_y", want.pos_y, got.pos_y);
            check_field("pos_z", want.pos_z, got.pos_z);
            check_field("tex_u", want.tex_u, got.tex_u);
            check_field("tex_v", want.tex_v, got.tex_v);
            check_field("valid_res", want.valid_res, got.valid_res);
         end
      end
   end

   initial begin : watchdog
      #(5_000_000);
      $display("capsule_vertex_generator_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      logic [CFG_W-1:0] radius_set [6];
      logic [CFG_W-1:0] height_set [6];
      vertex_req_type   rq;
      radius_set = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd256};
      height_set = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd512};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_CAP_RADIUS;
      csr_wdata  = '0;
      mdl_radius = 16'd256;
      mdl_height = 16'd512;
      idle_on    = 1'b1;
      fail_count = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         rq.sec   = DIR_ROWS[i].sec;
         rq.ring  = DIR_ROWS[i].ring;
         rq.slice = DIR_ROWS[i].slice;
         send_request(rq, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
      repeat (130) send_request(random_request(), 1'b0, '0);
      drain();

      // extremes of radius and height, one random pair, then back to reset values
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 4) begin
            radius_set[ph] = CFG_W'($urandom_range(0, 65535));
            height_set[ph] = CFG_W'($urandom_range(0, 65535));
         end
         if (ph == 5) idle_on = 1'b0;
         write_csr(CSR_CAP_RADIUS, radius_set[ph]);
         write_csr(CSR_BODY_HEIGHT, height_set[ph]);
         @(negedge clock);
         csr_we <= 1'b0;
         repeat (135) send_request(random_request(), 1'b0, '0);
         drain();
      end

      if (fail_count == 0 && vertex_q.size() == 0) begin
         $display("capsule_vertex_generator_tb: done, clean");
      end else begin
         $display("capsule_vertex_generator_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cvg_pkg.sv
rtl/core/cvg_lookup.sv
rtl/core/cvg_mult.sv
rtl/core/cvg_round.sv
rtl/core/capsule_vertex_generator.sv
rtl/core/cvg_checker.sv
dv/capsule_vertex_generator_tb.sv
